// ===== hdl/assert_macros.svh =====
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/npc_pkg.sv =====
// shared constants, types and the cordic angle table of the preamble correlator
package npc_pkg;

  localparam int PREAMBLE_LENGTH = 64;
  localparam int SAMPLE_BITS     = 16;
  localparam int PROD_BITS       = 2 * SAMPLE_BITS + 1;
  localparam int CORR_BITS       = 39;
  localparam int THR_BITS        = 17;
  localparam int ENERGY_BITS     = 38;
  localparam int CFG_BITS        = 38;
  localparam int PHASE_BITS      = 16;
  localparam int MUL_A_BITS      = 110;
  localparam int MUL_B_BITS      = 39;
  localparam int P_BITS          = 2 * ENERGY_BITS;
  localparam int T2_BITS         = 2 * THR_BITS;
  localparam int LHS_BITS        = 2 * CORR_BITS;
  localparam int CORDIC_STEPS    = 16;
  localparam int STEP_BITS       = 4;
  localparam int ANGLE_BITS      = 23;
  localparam int XY_BITS         = 42;

  localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 17'd58982;
  localparam logic signed [ANGLE_BITS-1:0] ANGLE_HALF_PI = 23'sd524288;

  // operation codes of an input word
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // register indexes
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_ENERGY    = 1'b1;

  // multiplier passes
  localparam logic [2:0] MUL_P   = 3'd0;
  localparam logic [2:0] MUL_T2  = 3'd1;
  localparam logic [2:0] MUL_RHS = 3'd2;
  localparam logic [2:0] MUL_LRE = 3'd3;
  localparam logic [2:0] MUL_LIM = 3'd4;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_OLD,
    S_NEW,
    S_ESUM,
    S_CORR,
    S_DRAIN,
    S_MGO,
    S_MWAIT,
    S_CGO,
    S_CWAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic issue;
    logic first;
  } mac_ctl_t;

  typedef struct packed {
    logic start;
    logic keep;
  } mul_ctl_t;

  // atan(2^-i) with pi = 2^20
  function automatic logic signed [ANGLE_BITS-1:0] cordic_angle(input logic [STEP_BITS-1:0] i);
    logic signed [ANGLE_BITS-1:0] a;
    case (i)
      4'd0:    a = 23'sd262144;
      4'd1:    a = 23'sd154753;
      4'd2:    a = 23'sd81767;
      4'd3:    a = 23'sd41506;
      4'd4:    a = 23'sd20834;
      4'd5:    a = 23'sd10427;
      4'd6:    a = 23'sd5215;
      4'd7:    a = 23'sd2608;
      4'd8:    a = 23'sd1304;
      4'd9:    a = 23'sd652;
      4'd10:   a = 23'sd326;
      4'd11:   a = 23'sd163;
      4'd12:   a = 23'sd81;
      4'd13:   a = 23'sd41;
      4'd14:   a = 23'sd20;
      4'd15:   a = 23'sd10;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/npc_cmac.sv =====
// complex multiply with conjugate and accumulate, one product per cycle
module npc_cmac (
  input  logic                                      clk,
  input  logic                                      rst,
  input  npc_pkg::mac_ctl_t                         ctl,
  input  logic signed [npc_pkg::SAMPLE_BITS-1:0]    a_re,
  input  logic signed [npc_pkg::SAMPLE_BITS-1:0]    a_im,
  input  logic signed [npc_pkg::SAMPLE_BITS-1:0]    b_re,
  input  logic signed [npc_pkg::SAMPLE_BITS-1:0]    b_im,
  output logic signed [npc_pkg::PROD_BITS-1:0]      prod_re,
  output logic signed [npc_pkg::CORR_BITS-1:0]      acc_re,
  output logic signed [npc_pkg::CORR_BITS-1:0]      acc_im
);

  logic signed [2*npc_pkg::SAMPLE_BITS-1:0] m_rr, m_ii, m_ir, m_ri;
  logic signed [npc_pkg::PROD_BITS-1:0]     prod_im;
  logic                                     prod_valid;
  logic                                     prod_first;

  assign m_rr = a_re * b_re;
  assign m_ii = a_im * b_im;
  assign m_ir = a_im * b_re;
  assign m_ri = a_re * b_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      prod_first <= 1'b0;
    end else begin
      prod_valid <= ctl.issue;
      prod_first <= ctl.first;
    end
  end

  // a * conj(b)
  always_ff @(posedge clk) begin
    prod_re <= npc_pkg::PROD_BITS'(m_rr) + npc_pkg::PROD_BITS'(m_ii);
    prod_im <= npc_pkg::PROD_BITS'(m_ir) - npc_pkg::PROD_BITS'(m_ri);
  end

  always_ff @(posedge clk) begin
    if (prod_valid) begin
      if (prod_first) begin
        acc_re <= npc_pkg::CORR_BITS'(prod_re);
        acc_im <= npc_pkg::CORR_BITS'(prod_im);
      end else begin
        acc_re <= acc_re + npc_pkg::CORR_BITS'(prod_re);
        acc_im <= acc_im + npc_pkg::CORR_BITS'(prod_im);
      end
    end
  end

endmodule

// ===== hdl/npc_mul.sv =====
// shift-add multiplier, one multiplier bit per cycle, optional accumulate
module npc_mul (
  input  logic                             clk,
  input  logic                             rst,
  input  npc_pkg::mul_ctl_t                ctl,
  input  logic [npc_pkg::MUL_A_BITS-1:0]   a_in,
  input  logic [npc_pkg::MUL_B_BITS-1:0]   b_in,
  output logic [npc_pkg::MUL_A_BITS-1:0]   acc,
  output logic                             busy
);

  logic [npc_pkg::MUL_A_BITS-1:0] a;
  logic [npc_pkg::MUL_B_BITS-1:0] b;

  assign busy = (b != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      b <= '0;
    end else if (ctl.start) begin
      b <= b_in;
    end else if (busy) begin
      b <= b >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a <= a_in;
      if (!ctl.keep) begin
        acc <= '0;
      end
    end else if (busy) begin
      a <= a << 1;
      if (b[0]) begin
        acc <= acc + a;
      end
    end
  end

endmodule

// ===== hdl/npc_cordic.sv =====
// iterative cordic vectoring, one micro-rotation per cycle, gives atan2 with pi = 32768
module npc_cordic (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic signed [npc_pkg::CORR_BITS-1:0]    x_in,
  input  logic signed [npc_pkg::CORR_BITS-1:0]    y_in,
  output logic                                    busy,
  output logic signed [npc_pkg::PHASE_BITS-1:0]   phase
);

  logic signed [npc_pkg::XY_BITS-1:0]    x, y, xe, ye, xs, ys;
  logic signed [npc_pkg::ANGLE_BITS-1:0] z, zr;
  logic [npc_pkg::STEP_BITS-1:0]         i;

  assign xe = npc_pkg::XY_BITS'(x_in);
  assign ye = npc_pkg::XY_BITS'(y_in);
  assign xs = x >>> i;
  assign ys = y >>> i;
  assign zr = (z + npc_pkg::ANGLE_BITS'(16)) >>> 5;
  assign phase = zr[npc_pkg::PHASE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      i    <= '0;
    end else if (start) begin
      busy <= (x_in != '0) || (y_in != '0);
      i    <= '0;
    end else if (busy) begin
      i <= i + 1'b1;
      if (i == npc_pkg::STEP_BITS'(npc_pkg::CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // left half plane is turned by a quarter turn first
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x <= ye;
          y <= -xe;
          z <= npc_pkg::ANGLE_HALF_PI;
        end else begin
          x <= -ye;
          y <= xe;
          z <= -npc_pkg::ANGLE_HALF_PI;
        end
      end else begin
        x <= xe;
        y <= ye;
        z <= '0;
      end
    end else if (busy) begin
      if (y < 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - npc_pkg::cordic_angle(i);
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + npc_pkg::cordic_angle(i);
      end
    end
  end

endmodule

// ===== hdl/normalized_preamble_correlator.sv =====
// normalized preamble correlator top level: sequencer, window and tap memories
//
// Input words arrive on item_valid/item_ready. operation = load writes one preamble tap;
// taps at index PREAMBLE_LENGTH and above are dropped. operation = sample
// shifts the sample into the window and yields one result word on
// result_valid/result_ready: oldest sample, correlation, detect flag and phase.
// A sample first updates the window energy and then runs the correlation over all taps
// (one complex tap product per cycle in the shared mac), then five passes of the
// shift-add multiplier, then the cordic when detected. The multiplier takes one
// bit per cycle. item_ready is low while a sample is in work.
// A finished result sits in the output register; the next word is accepted while it
// waits, and a later result waits in the sequencer until result_ready takes the first.
// Registers are written through cfg_write/cfg_index/cfg_data; the user must write them
// only while idle, which the block does not enforce. After rst the block zeroes window
// and tap memories with item_ready low; registers return to their reset values at once.
module normalized_preamble_correlator #(
  parameter int PREAMBLE_LENGTH = npc_pkg::PREAMBLE_LENGTH
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    item_valid,
  output logic                                    item_ready,
  input  logic                                    operation,
  input  logic signed [npc_pkg::SAMPLE_BITS-1:0]  sample_real,
  input  logic signed [npc_pkg::SAMPLE_BITS-1:0]  sample_imag,
  input  logic [5:0]                              tap_index,
  input  logic signed [npc_pkg::SAMPLE_BITS-1:0]  tap_real,
  input  logic signed [npc_pkg::SAMPLE_BITS-1:0]  tap_imag,
  output logic                                    result_valid,
  input  logic                                    result_ready,
  output logic signed [npc_pkg::SAMPLE_BITS-1:0]  delayed_real,
  output logic signed [npc_pkg::SAMPLE_BITS-1:0]  delayed_imag,
  output logic signed [npc_pkg::CORR_BITS-1:0]    corr_real,
  output logic signed [npc_pkg::CORR_BITS-1:0]    corr_imag,
  output logic                                    detected,
  output logic signed [npc_pkg::PHASE_BITS-1:0]   phase_estimate,
  input  logic                                    cfg_write,
  input  logic                                    cfg_index,
  input  logic [npc_pkg::CFG_BITS-1:0]            cfg_data
);

  `include "assert_macros.svh"

  localparam int PW = (PREAMBLE_LENGTH > 1) ? $clog2(PREAMBLE_LENGTH) : 1;
  localparam int SB = npc_pkg::SAMPLE_BITS;
  localparam logic [PW-1:0] LAST = PW'(PREAMBLE_LENGTH - 1);

  npc_pkg::state_t state, state_next;

  logic [SB*2-1:0] win_mem [PREAMBLE_LENGTH];
  logic [SB*2-1:0] tap_mem [PREAMBLE_LENGTH];
  logic [SB*2-1:0] win_q, tap_q, win_wdata, tap_wdata;
  logic [PW-1:0]   win_waddr, win_raddr, tap_waddr, tap_raddr;
  logic            win_we, tap_we;

  logic [npc_pkg::THR_BITS-1:0]    threshold;
  logic [npc_pkg::ENERGY_BITS-1:0] penergy, esum;
  logic [2*SB-1:0]                 eold;
  logic [PW-1:0]                   wp, wp_inc, k, clr_addr;
  logic                            drain;
  logic [2:0]                      mstep;
  logic signed [SB-1:0]            s_re, s_im, wq_re, wq_im, tq_re, tq_im;
  logic signed [SB-1:0]            mac_a_re, mac_a_im, mac_b_re, mac_b_im;
  logic signed [SB-1:0]            del_re, del_im;
  logic signed [npc_pkg::CORR_BITS-1:0] cr, ci, acc_re, acc_im;
  logic [npc_pkg::CORR_BITS-1:0]   cr_abs, ci_abs;
  logic signed [npc_pkg::PROD_BITS-1:0] prod_re;
  logic [npc_pkg::P_BITS-1:0]      p_reg;
  logic [npc_pkg::MUL_A_BITS-1:0]  rhs, lhs, mul_a, mul_acc;
  logic [npc_pkg::MUL_B_BITS-1:0]  mul_b;
  logic                            mul_busy, cordic_busy, cordic_start, det, det_calc;
  logic signed [npc_pkg::PHASE_BITS-1:0] cordic_phase;
  logic                            accept_in, load_ok, out_free;
  npc_pkg::mac_ctl_t               mac_ctl;
  npc_pkg::mul_ctl_t               mul_ctl;

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a, input logic [PW:0] b);
    logic [PW+1:0] s;
    s = {2'b00, a} + {1'b0, b};
    if (s >= (PW+2)'(PREAMBLE_LENGTH)) begin
      s = s - (PW+2)'(PREAMBLE_LENGTH);
    end
    return s[PW-1:0];
  endfunction

  assign accept_in = item_valid && item_ready;
  assign load_ok   = (32'(tap_index) < PREAMBLE_LENGTH);
  assign out_free  = !result_valid || result_ready;
  assign wp_inc    = (wp == LAST) ? '0 : wp + 1'b1;
  assign wq_re     = win_q[2*SB-1:SB];
  assign wq_im     = win_q[SB-1:0];
  assign tq_re     = tap_q[2*SB-1:SB];
  assign tq_im     = tap_q[SB-1:0];
  assign cr_abs    = cr[npc_pkg::CORR_BITS-1] ? -cr : cr;
  assign ci_abs    = ci[npc_pkg::CORR_BITS-1] ? -ci : ci;
  assign lhs       = {mul_acc[npc_pkg::LHS_BITS-1:0], 32'h0};
  assign det_calc  = (lhs >= rhs) && !((cr == '0) && (ci == '0) && (threshold != '0));

  // memories
  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[win_waddr] <= win_wdata;
    end
    win_q <= win_mem[win_raddr];
  end

  always_ff @(posedge clk) begin
    if (tap_we) begin
      tap_mem[tap_waddr] <= tap_wdata;
    end
    tap_q <= tap_mem[tap_raddr];
  end

  npc_cmac u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mac_ctl),
    .a_re    (mac_a_re),
    .a_im    (mac_a_im),
    .b_re    (mac_b_re),
    .b_im    (mac_b_im),
    .prod_re (prod_re),
    .acc_re  (acc_re),
    .acc_im  (acc_im)
  );

  npc_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mul_ctl),
    .a_in (mul_a),
    .b_in (mul_b),
    .acc  (mul_acc),
    .busy (mul_busy)
  );

  npc_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .x_in  (cr),
    .y_in  (ci),
    .busy  (cordic_busy),
    .phase (cordic_phase)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= npc_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    item_ready   = 1'b0;
    win_we       = 1'b0;
    win_waddr    = wp;
    win_wdata    = {s_re, s_im};
    win_raddr    = wp;
    tap_we       = 1'b0;
    tap_waddr    = PW'(tap_index);
    tap_wdata    = {tap_real, tap_imag};
    tap_raddr    = '0;
    mac_ctl      = '0;
    mac_a_re     = wq_re;
    mac_a_im     = wq_im;
    mac_b_re     = wq_re;
    mac_b_im     = wq_im;
    mul_ctl      = '0;
    mul_a        = '0;
    mul_b        = '0;
    cordic_start = 1'b0;
    case (state)
      npc_pkg::S_CLEAR: begin
        win_we    = 1'b1;
        tap_we    = 1'b1;
        win_waddr = clr_addr;
        tap_waddr = clr_addr;
        win_wdata = '0;
        tap_wdata = '0;
        if (clr_addr == LAST) begin
          state_next = npc_pkg::S_IDLE;
        end
      end
      npc_pkg::S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          if (operation == npc_pkg::OP_LOAD) begin
            tap_we = load_ok;
          end else begin
            state_next = npc_pkg::S_OLD;
          end
        end
      end
      npc_pkg::S_OLD: begin
        // energy of the sample being evicted
        mac_ctl.issue = 1'b1;
        win_we        = 1'b1;
        state_next    = npc_pkg::S_NEW;
      end
      npc_pkg::S_NEW: begin
        mac_ctl.issue = 1'b1;
        mac_a_re      = s_re;
        mac_a_im      = s_im;
        mac_b_re      = s_re;
        mac_b_im      = s_im;
        state_next    = npc_pkg::S_ESUM;
      end
      npc_pkg::S_ESUM: begin
        win_raddr  = wp_inc;
        state_next = npc_pkg::S_CORR;
      end
      npc_pkg::S_CORR: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.first = (k == '0);
        mac_b_re      = tq_re;
        mac_b_im      = tq_im;
        win_raddr     = wrap_add(wp, {1'b0, k} + 1'b1);
        tap_raddr     = (k == LAST) ? '0 : k + 1'b1;
        if (k == LAST) begin
          state_next = npc_pkg::S_DRAIN;
        end
      end
      npc_pkg::S_DRAIN: begin
        if (drain) begin
          state_next = npc_pkg::S_MGO;
        end
      end
      npc_pkg::S_MGO: begin
        mul_ctl.start = 1'b1;
        case (mstep)
          npc_pkg::MUL_P: begin
            mul_a = npc_pkg::MUL_A_BITS'(esum);
            mul_b = npc_pkg::MUL_B_BITS'(penergy);
          end
          npc_pkg::MUL_T2: begin
            mul_a = npc_pkg::MUL_A_BITS'(threshold);
            mul_b = npc_pkg::MUL_B_BITS'(threshold);
          end
          npc_pkg::MUL_RHS: begin
            mul_a = npc_pkg::MUL_A_BITS'(p_reg);
            mul_b = npc_pkg::MUL_B_BITS'(mul_acc[npc_pkg::T2_BITS-1:0]);
          end
          npc_pkg::MUL_LRE: begin
            mul_a = npc_pkg::MUL_A_BITS'(cr_abs);
            mul_b = cr_abs;
          end
          npc_pkg::MUL_LIM: begin
            mul_a        = npc_pkg::MUL_A_BITS'(ci_abs);
            mul_b        = ci_abs;
            mul_ctl.keep = 1'b1;
          end
          default: begin
            mul_ctl.start = 1'b0;
          end
        endcase
        state_next = npc_pkg::S_MWAIT;
      end
      npc_pkg::S_MWAIT: begin
        if (!mul_busy) begin
          if (mstep == npc_pkg::MUL_LIM) begin
            state_next = det_calc ? npc_pkg::S_CGO : npc_pkg::S_OUT;
          end else begin
            state_next = npc_pkg::S_MGO;
          end
        end
      end
      npc_pkg::S_CGO: begin
        cordic_start = 1'b1;
        state_next   = npc_pkg::S_CWAIT;
      end
      npc_pkg::S_CWAIT: begin
        if (!cordic_busy) begin
          state_next = npc_pkg::S_OUT;
        end
      end
      npc_pkg::S_OUT: begin
        if (out_free) begin
          state_next = npc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = npc_pkg::S_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= npc_pkg::THRESHOLD_RESET;
      penergy   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        npc_pkg::REG_THRESHOLD: threshold <= cfg_data[npc_pkg::THR_BITS-1:0];
        npc_pkg::REG_ENERGY:    penergy   <= cfg_data;
        default:                penergy   <= penergy;
      endcase
    end
  end

  // sequencer control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      wp       <= '0;
      esum     <= '0;
      k        <= '0;
      drain    <= 1'b0;
      mstep    <= npc_pkg::MUL_P;
    end else begin
      case (state)
        npc_pkg::S_CLEAR: clr_addr <= clr_addr + 1'b1;
        npc_pkg::S_IDLE: begin
          k     <= '0;
          drain <= 1'b0;
          mstep <= npc_pkg::MUL_P;
        end
        npc_pkg::S_ESUM: begin
          esum <= esum - npc_pkg::ENERGY_BITS'(eold)
                  + npc_pkg::ENERGY_BITS'(prod_re[2*SB-1:0]);
          wp   <= wp_inc;
        end
        npc_pkg::S_CORR:  k <= k + 1'b1;
        npc_pkg::S_DRAIN: drain <= 1'b1;
        npc_pkg::S_MWAIT: begin
          if (!mul_busy) begin
            mstep <= mstep + 1'b1;
          end
        end
        default: drain <= drain;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept_in && operation == npc_pkg::OP_SAMPLE) begin
      s_re <= sample_real;
      s_im <= sample_imag;
    end
    if (state == npc_pkg::S_NEW) begin
      eold <= prod_re[2*SB-1:0];
    end
    if (state == npc_pkg::S_CORR && k == '0) begin
      del_re <= wq_re;
      del_im <= wq_im;
    end
    if (state == npc_pkg::S_DRAIN && drain) begin
      cr <= acc_re;
      ci <= acc_im;
    end
    if (state == npc_pkg::S_MWAIT && !mul_busy) begin
      case (mstep)
        npc_pkg::MUL_P:   p_reg <= mul_acc[npc_pkg::P_BITS-1:0];
        npc_pkg::MUL_RHS: rhs   <= mul_acc;
        npc_pkg::MUL_LIM: det   <= det_calc;
        default:          p_reg <= p_reg;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == npc_pkg::S_OUT && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == npc_pkg::S_OUT && out_free) begin
      delayed_real   <= del_re;
      delayed_imag   <= del_im;
      corr_real      <= cr;
      corr_imag      <= ci;
      detected       <= det;
      phase_estimate <= det ? cordic_phase : '0;
    end
  end

  `ASSERT_NXT(a_sample_starts, clk, rst, accept_in && operation == npc_pkg::OP_SAMPLE, state == npc_pkg::S_OLD, "sample word did not start the energy update")
  `ASSERT_IMP(a_idle_units_quiet, clk, rst, state == npc_pkg::S_IDLE, !mul_busy && !cordic_busy, "arithmetic unit busy while idle")
  `ASSERT_IMP(a_phase_zero, clk, rst, result_valid && !detected, phase_estimate == '0, "phase given without detection")
  `ASSERT_IMP(a_cordic_in_wait, clk, rst, cordic_busy, state == npc_pkg::S_CWAIT, "cordic running outside its wait state")

endmodule

// ===== tb/normalized_preamble_correlator_tb.sv =====
// testbench of the normalized preamble correlator: directed and random words checked against a predictor
module normalized_preamble_correlator_tb;

  localparam int NTAP = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  logic operation = npc_pkg::OP_SAMPLE;
  logic signed [15:0] sample_real = '0, sample_imag = '0, tap_real = '0, tap_imag = '0;
  logic [5:0] tap_index = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic signed [15:0] delayed_real, delayed_imag, phase_estimate;
  logic signed [38:0] corr_real, corr_imag;
  logic detected;
  logic cfg_write = 1'b0;
  logic cfg_index = npc_pkg::REG_THRESHOLD;
  logic [37:0] cfg_data = '0;

  typedef struct {
    logic signed [15:0] dre, dim;
    logic signed [38:0] cre, cim;
    logic det;
    logic signed [15:0] ph;
  } corr_result_t;

  corr_result_t pending_results[$];
  int errors = 0;
  int n_samples = 0, n_loads = 0, n_detects = 0;
  int ready_mode = 0;

  // predictor state
  logic signed [15:0] win_re[NTAP], win_im[NTAP], tap_re[NTAP], tap_im[NTAP];
  int unsigned wr_ptr;
  logic [37:0] win_energy;
  logic [16:0] thr;
  logic [37:0] pre_energy;

  normalized_preamble_correlator u_top (.*);

  always #2 clk = ~clk;

  function automatic logic signed [41:0] fshift(logic signed [41:0] v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [15:0] cordic_phase(logic signed [38:0] cx,
                                                     logic signed [38:0] cy);
    logic signed [41:0] x, y, t, xs, ys;
    logic signed [31:0] z;
    logic signed [22:0] angles[16];
    angles = '{262144, 154753, 81767, 41506, 20834, 10427, 5215, 2608,
               1304, 652, 326, 163, 81, 41, 20, 10};
    x = cx;
    y = cy;
    z = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      if (y >= 0) begin
        z = 524288; t = x; x = y; y = -t;
      end else begin
        z = -524288; t = x; x = -y; y = t;
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = fshift(x, i);
      ys = fshift(y, i);
      if (y < 0) begin
        x = x - ys; y = y + xs; z = z - angles[i];
      end else begin
        x = x + ys; y = y - xs; z = z + angles[i];
      end
    end
    z = (z + 16) >>> 5;
    return z[15:0];
  endfunction

  task automatic predict_sample(logic signed [15:0] sr, logic signed [15:0] si);
    corr_result_t r;
    logic signed [63:0] acc_re, acc_im;
    logic [33:0] e_old, e_new;
    logic [77:0] mag2;
    logic [155:0] lhs, rhs;
    int unsigned j;
    e_old = 34'(win_re[wr_ptr] * win_re[wr_ptr] + win_im[wr_ptr] * win_im[wr_ptr]);
    e_new = 34'(sr * sr + si * si);
    win_energy = win_energy - 38'(e_old) + 38'(e_new);
    win_re[wr_ptr] = sr;
    win_im[wr_ptr] = si;
    wr_ptr = (wr_ptr + 1) % NTAP;
    acc_re = 0;
    acc_im = 0;
    for (int k = 0; k < NTAP; k++) begin
      j = (wr_ptr + k) % NTAP;
      acc_re += 64'(win_re[j]) * tap_re[k] + 64'(win_im[j]) * tap_im[k];
      acc_im += 64'(win_im[j]) * tap_re[k] - 64'(win_re[j]) * tap_im[k];
    end
    r.cre = acc_re[38:0];
    r.cim = acc_im[38:0];
    mag2 = 78'(r.cre * r.cre) + 78'(r.cim * r.cim);
    lhs = 156'(mag2) << 32;
    rhs = 156'(thr) * 156'(thr) * 156'(win_energy) * 156'(pre_energy);
    r.det = lhs >= rhs;
    // zero correlation only passes a zero threshold
    if (r.cre == 0 && r.cim == 0 && thr != 0) r.det = 1'b0;
    r.ph = r.det ? cordic_phase(r.cre, r.cim) : '0;
    r.dre = win_re[wr_ptr];
    r.dim = win_im[wr_ptr];
    if (r.det) n_detects++;
    pending_results.push_back(r);
  endtask

  function automatic int gap_length();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) n = 0;
    return n;
  endfunction

  task automatic send_word(logic op, logic signed [15:0] sr, logic signed [15:0] si,
                           logic [5:0] idx, logic signed [15:0] tr,
                           logic signed [15:0] ti);
    int n;
    item_valid <= 1'b1;
    operation <= op;
    sample_real <= sr;
    sample_imag <= si;
    tap_index <= idx;
    tap_real <= tr;
    tap_imag <= ti;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (op == npc_pkg::OP_LOAD) begin
      tap_re[idx] = tr;
      tap_im[idx] = ti;
      n_loads++;
    end else begin
      predict_sample(sr, si);
      n_samples++;
    end
    // with no gap valid stays up for the next word
    n = gap_length();
    if (n != 0) begin
      item_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_sample(logic signed [15:0] sr, logic signed [15:0] si);
    send_word(npc_pkg::OP_SAMPLE, sr, si, 6'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic send_tap(logic [5:0] idx, logic signed [15:0] tr, logic signed [15:0] ti);
    send_word(npc_pkg::OP_LOAD, 16'($urandom), 16'($urandom), idx, tr, ti);
  endtask

  task automatic drain();
    int guard;
    item_valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [37:0] val);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == npc_pkg::REG_THRESHOLD) thr = val[16:0];
    else pre_energy = val;
  endtask

  // result checker
  always @(posedge clk) begin
    corr_result_t e;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word corr %0d %0d", $time, corr_real, corr_imag);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (delayed_real !== e.dre || delayed_imag !== e.dim) begin
          $display("%0t: delayed expected %0d %0d actual %0d %0d", $time,
                   e.dre, e.dim, delayed_real, delayed_imag);
          errors++;
        end
        if (corr_real !== e.cre || corr_imag !== e.cim) begin
          $display("%0t: corr expected %0d %0d actual %0d %0d", $time,
                   e.cre, e.cim, corr_real, corr_imag);
          errors++;
        end
        if (detected !== e.det || phase_estimate !== e.ph) begin
          $display("%0t: detect/phase expected %0b %0d actual %0b %0d", $time,
                   e.det, e.ph, detected, phase_estimate);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    case (ready_mode)
      0: result_ready <= 1'b1;
      default: result_ready <= ($urandom_range(0, 9) == 0) ? 1'b0 :
                               ($urandom_range(0, 2) != 0);
    endcase
  end

  task automatic test_directed_extremes();
    send_sample(16'sh7fff, 16'sh7fff);
    send_tap(6'd0, 16'sh7fff, -16'sh8000);
    send_tap(6'd63, -16'sh8000, -16'sh8000);
    send_tap(6'd1, 16'sh0000, 16'sh7fff);
    for (int i = 0; i < 4; i++) send_sample(-16'sh8000, -16'sh8000);
    send_sample(16'sh7fff, -16'sh8000);
    send_sample(16'sh0000, 16'sh0000);
    send_sample(16'sh0001, -16'sh0001);
  endtask

  task automatic test_threshold_zero();
    write_reg(npc_pkg::REG_THRESHOLD, 38'd0);
    for (int i = 0; i < 64; i++) send_tap(6'(i), 16'sh0000, 16'sh0000);
    send_sample(16'sh0000, 16'sh0000);
    send_sample(16'sh1234, -16'sh4321);
  endtask

  task automatic test_preamble_match();
    logic signed [15:0] pr[NTAP], pi[NTAP];
    logic [37:0] ep;
    ep = 0;
    for (int i = 0; i < NTAP; i++) begin
      pr[i] = 16'($urandom_range(0, 8000)) - 16'sd4000;
      pi[i] = 16'($urandom_range(0, 8000)) - 16'sd4000;
      ep += 38'(pr[i] * pr[i] + pi[i] * pi[i]);
      send_tap(6'(i), pr[i], pi[i]);
    end
    write_reg(npc_pkg::REG_ENERGY, ep);
    write_reg(npc_pkg::REG_THRESHOLD, 38'($urandom_range(40000, 65536)));
    for (int r = 0; r < 4; r++) begin
      for (int i = 0; i < NTAP; i++) send_sample(pr[i], pi[i]);
      for (int i = 0; i < 6; i++) send_sample(16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_random_mixed(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 5) == 0)
        send_tap(6'($urandom), 16'($urandom), 16'($urandom));
      else if ($urandom_range(0, 3) == 0)
        send_sample(16'($urandom_range(0, 64)) - 16'sd32, 16'($urandom_range(0, 64)) - 16'sd32);
      else
        send_sample(16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_register_settings();
    write_reg(npc_pkg::REG_THRESHOLD, 38'd65536);
    write_reg(npc_pkg::REG_ENERGY, 38'h3f_ffff_ffff);
    test_random_mixed(150);
    write_reg(npc_pkg::REG_THRESHOLD, 38'h1_ffff);
    write_reg(npc_pkg::REG_ENERGY, 38'd0);
    test_random_mixed(150);
    write_reg(npc_pkg::REG_THRESHOLD, 38'd1);
    write_reg(npc_pkg::REG_ENERGY, 38'($urandom) << 6);
    test_random_mixed(150);
  endtask

  initial begin
    for (int i = 0; i < NTAP; i++) begin
      win_re[i] = '0; win_im[i] = '0; tap_re[i] = '0; tap_im[i] = '0;
    end
    wr_ptr = 0;
    win_energy = '0;
    thr = npc_pkg::THRESHOLD_RESET;
    pre_energy = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_threshold_zero();
    ready_mode = 1;
    test_preamble_match();
    test_register_settings();
    write_reg(npc_pkg::REG_THRESHOLD, 38'd58982);
    test_preamble_match();
    test_random_mixed(640);
    drain();
    $display("covered %0d samples, %0d tap loads, %0d detections", n_samples, n_loads,
             n_detects);
    $display("threshold and energy swept through zero, maximum and typical settings");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
